[hw/rtl/fractional_feedback_echo_macros.svh]
// assertion helpers used by the checker file
`ifndef FRACTIONAL_FEEDBACK_ECHO_MACROS_SVH
`define FRACTIONAL_FEEDBACK_ECHO_MACROS_SVH

// same-cycle implication, clocked on aclk, quiet during reset
`define FFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, quiet during reset
`define FFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ffe_pkg.sv]
package ffe_pkg;

    localparam int DEFAULT_MAX_DELAY   = 262144;
    localparam int DEFAULT_SAMPLE_BITS = 24;

    localparam int DELAY_W    = 26;
    localparam int GAIN_W     = 16;
    localparam int MIX_W      = 17;
    localparam int FRAC_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 26;

    localparam logic [DELAY_W-1:0] DELAY_RESET = '0;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd19661;
    localparam logic [MIX_W-1:0]   WET_RESET   = 17'd32768;
    localparam logic [MIX_W-1:0]   MIX_UNITY   = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY    = 2'd0,
        REG_FEEDBACK = 2'd1,
        REG_WET      = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [DELAY_W-1:0] delay_q8;
        logic [GAIN_W-1:0]  feedback_gain;
        logic [MIX_W-1:0]   wet_mix;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_INTERP,
        ST_MUL_FB,
        ST_WRITE,
        ST_MUL_WET,
        ST_MIX
    } state_t;

endpackage

[hw/rtl/fractional_feedback_echo.sv]
// fractional feedback echo: each item on the slave stream is one signed mono sample; the block
// reads the sample delay_q8/256 samples back from a circular echo memory of MAX_DELAY entries,
// interpolating linearly between the two neighbouring entries, writes input plus delayed times
// feedback_gain (saturated) back into the memory and sends out the dry/wet mix, also saturated,
// one result item per input item. the delay is clamped to [1/256, MAX_DELAY-1] samples and a
// wet share above 1.0 counts as fully wet. an item occupies the block from the cycle in which
// it is accepted through seven steps, set by the single read port of the echo memory (two
// reads per item), one write-back and a shared multiplier used three times in turn; the last
// step loads the result into the output register, waiting while an earlier one still stalls
// there. one item is in flight at a time; the next is taken while the finished result still
// waits in the output register. the memory needs no clearing pass after reset: entries not yet
// written since reset read as zero, so items are accepted from the first cycle after reset.
// configuration is to be written through the cfg port (index 0 delay_q8, 1 feedback_gain,
// 2 wet_mix, others ignored) only while no item is in flight; the block does not enforce it.
module fractional_feedback_echo #(
    parameter int MAX_DELAY   = ffe_pkg::DEFAULT_MAX_DELAY,
    parameter int SAMPLE_BITS = ffe_pkg::DEFAULT_SAMPLE_BITS,
    localparam int TDATA_W    = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int ADDR_W     = $clog2(MAX_DELAY)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input item stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [TDATA_W-1:0]                 s_tdata,   // sample_in, zero padded to bytes
    // result item stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [TDATA_W-1:0]                 m_tdata,   // sample_out, zero padded to bytes
    // register writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ffe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ffe_pkg::cfg_t cfg;

    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic signed [SAMPLE_BITS-1:0] sample_out;

    // echo memory port signals
    logic                          mem_rd_en;
    logic [ADDR_W-1:0]             mem_rd_addr;
    logic signed [SAMPLE_BITS-1:0] mem_rd_data;
    logic                          mem_wr_en;
    logic [ADDR_W-1:0]             mem_wr_addr;
    logic signed [SAMPLE_BITS-1:0] mem_wr_data;

    // padding bits of s_tdata are ignored
    assign sample_in = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign m_tdata   = TDATA_W'($unsigned(sample_out));

    ffe_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ffe_echo_mem #(
        .MAX_DELAY   (MAX_DELAY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_echo_mem (
        .aclk    (aclk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // sequencer: clamp and address, two reads, interpolate, feedback write-back, mix
    ffe_datapath #(
        .MAX_DELAY   (MAX_DELAY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_tvalid),
        .s_ready     (s_tready),
        .s_sample    (sample_in),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_sample    (sample_out),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

endmodule

[hw/rtl/ffe_cfg_regs.sv]
module ffe_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ffe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ffe_pkg::CFG_DATA_W-1:0]     cfg_data,
    output ffe_pkg::cfg_t                      cfg
);

    ffe_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.delay_q8      <= ffe_pkg::DELAY_RESET;
            cfg_reg.feedback_gain <= ffe_pkg::GAIN_RESET;
            cfg_reg.wet_mix       <= ffe_pkg::WET_RESET;
        end else if (cfg_valid) begin
            // unknown indexes are dropped
            case (ffe_pkg::reg_idx_t'(cfg_index))
                ffe_pkg::REG_DELAY: begin
                    cfg_reg.delay_q8 <= cfg_data[ffe_pkg::DELAY_W-1:0];
                end
                ffe_pkg::REG_FEEDBACK: begin
                    cfg_reg.feedback_gain <= cfg_data[ffe_pkg::GAIN_W-1:0];
                end
                ffe_pkg::REG_WET: begin
                    cfg_reg.wet_mix <= cfg_data[ffe_pkg::MIX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

[hw/rtl/ffe_echo_mem.sv]
module ffe_echo_mem #(
    parameter int MAX_DELAY   = ffe_pkg::DEFAULT_MAX_DELAY,
    parameter int SAMPLE_BITS = ffe_pkg::DEFAULT_SAMPLE_BITS,
    localparam int ADDR_W     = $clog2(MAX_DELAY)
) (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr,
    output logic signed [SAMPLE_BITS-1:0] rd_data,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic signed [SAMPLE_BITS-1:0] wr_data
);

    logic signed [SAMPLE_BITS-1:0] mem [MAX_DELAY];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/ffe_datapath.sv]
module ffe_datapath #(
    parameter int MAX_DELAY   = ffe_pkg::DEFAULT_MAX_DELAY,
    parameter int SAMPLE_BITS = ffe_pkg::DEFAULT_SAMPLE_BITS,
    localparam int ADDR_W     = $clog2(MAX_DELAY)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ffe_pkg::cfg_t                 cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_sample,
    output logic                          mem_rd_en,
    output logic [ADDR_W-1:0]             mem_rd_addr,
    input  logic signed [SAMPLE_BITS-1:0] mem_rd_data,
    output logic                          mem_wr_en,
    output logic [ADDR_W-1:0]             mem_wr_addr,
    output logic signed [SAMPLE_BITS-1:0] mem_wr_data
);

    localparam int SB   = SAMPLE_BITS;
    localparam int FW   = ffe_pkg::FRAC_W;
    localparam int DQ_W = (ADDR_W + FW > ffe_pkg::DELAY_W) ? ADDR_W + FW : ffe_pkg::DELAY_W;
    localparam int IW   = SB + 11;
    localparam int OPW  = ffe_pkg::MIX_W + 1;
    localparam int PW   = SB + OPW;
    localparam int SW   = SB + 2;

    localparam logic [DQ_W-1:0]         DMAX   = DQ_W'((MAX_DELAY - 1) * 256);
    localparam logic [ADDR_W:0]         MAX_E  = (ADDR_W + 1)'(MAX_DELAY);
    localparam logic [ADDR_W-1:0]       LAST   = ADDR_W'(MAX_DELAY - 1);
    localparam logic signed [IW-1:0]    I_HALF = IW'(128);
    localparam logic signed [PW:0]      Q_HALF = (PW + 1)'(32768);
    localparam logic signed [SW-1:0]    SAT_MAX = {3'b000, {(SB - 1){1'b1}}};
    localparam logic signed [SW-1:0]    SAT_MIN = {3'b111, {(SB - 1){1'b0}}};

    ffe_pkg::state_t state_reg, state_next;

    logic signed [SB-1:0] x_reg;
    logic [FW-1:0]        df_reg;
    logic [ADDR_W-1:0]    addr_a_reg, addr_b_reg;
    logic                 ok_a_reg, ok_b_reg;
    logic signed [SB-1:0] v1_reg;
    logic signed [SB-1:0] delayed_reg;
    logic signed [PW-1:0] p_reg, acc_reg;
    logic [ADDR_W-1:0]    wp_reg;
    logic                 wrapped_reg;
    logic                 m_valid_reg;
    logic signed [SB-1:0] m_sample_reg;

    logic                 out_load;

    // delay clamp and address generation
    logic [DQ_W-1:0]      d_ext, d_cl;
    logic [ADDR_W:0]      age_a, age_b, wp_e;
    logic [ADDR_W-1:0]    addr_a_c, addr_b_c;
    logic [ffe_pkg::MIX_W-1:0] wet_c, dry_c;

    // arithmetic
    logic signed [SB-1:0] v2_c;
    logic signed [SB:0]   diff_c;
    logic signed [IW-1:0] interp_c;
    logic signed [SB-1:0] mul_a;
    logic signed [OPW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [PW-1:0] fb_shift;
    logic signed [SW-1:0] fb_sum;
    logic signed [SB-1:0] fb_sat;
    logic signed [PW:0]   mix_sum;
    logic signed [SW-1:0] mix_shift;
    logic signed [SB-1:0] mix_sat;

    always_comb begin
        d_ext = DQ_W'(cfg.delay_q8);
        if (d_ext == '0) begin
            d_cl = DQ_W'(1);
        end else if (d_ext > DMAX) begin
            d_cl = DMAX;
        end else begin
            d_cl = d_ext;
        end
        age_a = {1'b0, d_cl[ADDR_W+FW-1:FW]};
        age_b = age_a + 1'b1;
        wp_e  = {1'b0, wp_reg};
        addr_a_c = (wp_e >= age_a) ? ADDR_W'(wp_e - age_a) : ADDR_W'(wp_e + MAX_E - age_a);
        addr_b_c = (wp_e >= age_b) ? ADDR_W'(wp_e - age_b) : ADDR_W'(wp_e + MAX_E - age_b);
        wet_c = (cfg.wet_mix > ffe_pkg::MIX_UNITY) ? ffe_pkg::MIX_UNITY : cfg.wet_mix;
        dry_c = ffe_pkg::MIX_UNITY - wet_c;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ffe_pkg::ST_IDLE:    if (s_valid) state_next = ffe_pkg::ST_RD_A;
            ffe_pkg::ST_RD_A:    state_next = ffe_pkg::ST_RD_B;
            ffe_pkg::ST_RD_B:    state_next = ffe_pkg::ST_INTERP;
            ffe_pkg::ST_INTERP:  state_next = ffe_pkg::ST_MUL_FB;
            ffe_pkg::ST_MUL_FB:  state_next = ffe_pkg::ST_WRITE;
            ffe_pkg::ST_WRITE:   state_next = ffe_pkg::ST_MUL_WET;
            ffe_pkg::ST_MUL_WET: state_next = ffe_pkg::ST_MIX;
            ffe_pkg::ST_MIX:     if (!m_valid_reg || m_ready) state_next = ffe_pkg::ST_IDLE;
            default:             state_next = ffe_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_ready     = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = addr_a_reg;
        mem_wr_en   = 1'b0;
        out_load    = 1'b0;
        mul_a       = delayed_reg;
        mul_b       = '0;
        case (state_reg)
            ffe_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            ffe_pkg::ST_RD_A: begin
                mem_rd_en = 1'b1;
            end
            ffe_pkg::ST_RD_B: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = addr_b_reg;
            end
            ffe_pkg::ST_MUL_FB: begin
                mul_b = OPW'(cfg.feedback_gain);
            end
            ffe_pkg::ST_WRITE: begin
                mem_wr_en = 1'b1;
                mul_a     = x_reg;
                mul_b     = OPW'(dry_c);
            end
            ffe_pkg::ST_MUL_WET: begin
                mul_b = OPW'(wet_c);
            end
            ffe_pkg::ST_MIX: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        v2_c     = ok_b_reg ? mem_rd_data : '0;
        diff_c   = (SB + 1)'(v2_c) - (SB + 1)'(v1_reg);
        interp_c = (IW'(v1_reg) <<< FW) + IW'(diff_c) * IW'($signed({1'b0, df_reg})) + I_HALF;

        mul_p = PW'(mul_a) * PW'(mul_b);

        fb_shift = (p_reg + PW'(Q_HALF)) >>> 16;
        fb_sum   = SW'(x_reg) + SW'(fb_shift);
        if (fb_sum > SAT_MAX) begin
            fb_sat = SB'(SAT_MAX);
        end else if (fb_sum < SAT_MIN) begin
            fb_sat = SB'(SAT_MIN);
        end else begin
            fb_sat = SB'(fb_sum);
        end

        mix_sum   = (PW + 1)'(acc_reg) + (PW + 1)'(p_reg) + Q_HALF;
        mix_shift = SW'(mix_sum >>> 16);
        if (mix_shift > SAT_MAX) begin
            mix_sat = SB'(SAT_MAX);
        end else if (mix_shift < SAT_MIN) begin
            mix_sat = SB'(SAT_MIN);
        end else begin
            mix_sat = SB'(mix_shift);
        end
    end

    assign mem_wr_addr = wp_reg;
    assign mem_wr_data = fb_sat;
    assign m_valid     = m_valid_reg;
    assign m_sample    = m_sample_reg;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffe_pkg::ST_IDLE;
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (mem_wr_en) begin
                wp_reg <= (wp_reg == LAST) ? '0 : wp_reg + 1'b1;
                if (wp_reg == LAST) begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            x_reg      <= s_sample;
            df_reg     <= d_cl[FW-1:0];
            addr_a_reg <= addr_a_c;
            addr_b_reg <= addr_b_c;
            // entries never written since reset read as zero
            ok_a_reg   <= wrapped_reg || (addr_a_c < wp_reg);
            ok_b_reg   <= wrapped_reg || (addr_b_c < wp_reg);
        end
        if (state_reg == ffe_pkg::ST_RD_B) begin
            v1_reg <= ok_a_reg ? mem_rd_data : '0;
        end
        if (state_reg == ffe_pkg::ST_INTERP) begin
            delayed_reg <= SB'(interp_c >>> FW);
        end
        if (state_reg == ffe_pkg::ST_MUL_FB || state_reg == ffe_pkg::ST_WRITE
                || state_reg == ffe_pkg::ST_MUL_WET) begin
            p_reg <= mul_p;
        end
        if (state_reg == ffe_pkg::ST_MUL_WET) begin
            acc_reg <= p_reg;
        end
        if (out_load) begin
            m_sample_reg <= mix_sat;
        end
    end

endmodule

[hw/rtl/ffe_checker.sv]
`include "fractional_feedback_echo_macros.svh"

module ffe_checker #(
    parameter int TDATA_W = ((ffe_pkg::DEFAULT_SAMPLE_BITS + 7) / 8) * 8
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // a stalled result item holds
    `FFE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")

    // one item in flight: no second acceptance right after the first
    `FFE_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "item taken while another is in flight")

    // an idle block stays ready until an item arrives
    `FFE_ASSERT_NEXT(a_idle_stays_ready, s_tready && !s_tvalid, s_tready, "ready dropped with no item taken")

    // no result can appear the cycle after an acceptance
    `FFE_ASSERT_NEXT(a_no_instant_result, s_tvalid && s_tready, !$rose(m_tvalid), "result appeared too early")

endmodule

bind fractional_feedback_echo ffe_checker #(.TDATA_W(TDATA_W)) u_ffe_checker (.*);
